// ===== rtl/core/srt_pkg.sv =====
`default_nettype none
package srt_pkg;
    typedef enum logic [2:0] {
        OP_CHECK   = 3'd0,
        OP_RESERVE = 3'd1,
        OP_RELEASE = 3'd2,
        OP_QUERY   = 3'd3,
        OP_TICK    = 3'd4,
        OP_FREE    = 3'd5
    } t_op;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SAME  = 3'd1;
    localparam logic [2:0] ST_BUSY  = 3'd2;
    localparam logic [2:0] ST_OTHER = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;

    // one decoded command from front to back
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] in_port;
        logic [1:0] in_vc;
        logic [2:0] out_port;
        logic       po_ok;
        logic       pair_ok;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [2:0] granted_out;
        logic [1:0] granted_vc;
        logic       out_free;
        logic       last;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/core/srt_front.sv =====
`default_nettype none
module srt_front #(
    parameter int NUM_OUTPUTS = 5,
    parameter int NUM_INPUTS  = 5,
    parameter int NUM_VCS     = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [10:0]   i_data,
    output srt_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);
    import srt_pkg::*;

    // two-entry queue of decoded commands
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_dec;
    logic       w_push, w_pop;

    // decode and range classification
    always_comb begin
        w_dec.op       = i_data[2:0];
        w_dec.in_port  = i_data[5:3];
        w_dec.in_vc    = i_data[7:6];
        w_dec.out_port = i_data[10:8];
        w_dec.po_ok    = 32'(i_data[10:8]) < NUM_OUTPUTS;
        w_dec.pair_ok  = (32'(i_data[5:3]) < NUM_INPUTS) && (32'(i_data[7:6]) < NUM_VCS);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready && (i_data[2:0] <= OP_FREE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_dec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/srt_back.sv =====
`default_nettype none
module srt_back #(
    parameter int NUM_OUTPUTS = 5,
    parameter int NUM_VCS     = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire srt_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output srt_pkg::t_res      o_res
);
    import srt_pkg::*;

    localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int VW = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
    localparam int CW = $clog2(NUM_VCS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_QUERY = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    logic [2:0]    r_ei  [NUM_OUTPUTS][NUM_VCS];
    logic [1:0]    r_ev  [NUM_OUTPUTS][NUM_VCS];
    logic [CW-1:0] r_cnt [NUM_OUTPUTS];
    logic [VW-1:0] r_rr  [NUM_OUTPUTS];

    t_state     r_state;
    t_cmd       r_cmd;
    logic [OW-1:0] r_o;
    logic       r_any;
    t_res       r_res;
    logic       r_ov;

    logic [OW-1:0] w_po;
    assign w_po = i_cmd.out_port[OW-1:0];

    // per-output match flags for check and release
    logic [NUM_OUTPUTS-1:0] w_other;
    logic w_same, w_busy, w_hit;
    logic [VW-1:0] w_hidx;
    logic [2:0] w_chk;
    always_comb begin
        w_other = '0;
        w_same = 1'b0; w_busy = 1'b0; w_hit = 1'b0; w_hidx = '0;
        for (int o = 0; o < NUM_OUTPUTS; o++)
            for (int v = 0; v < NUM_VCS; v++)
                if (CW'(v) < r_cnt[o] && r_ei[o][v] == i_cmd.in_port &&
                    r_ev[o][v] == i_cmd.in_vc && OW'(o) != w_po)
                    w_other[o] = 1'b1;
        for (int v = NUM_VCS - 1; v >= 0; v--)
            if (CW'(v) < r_cnt[w_po] && r_ev[w_po][v] == i_cmd.in_vc) begin
                w_same = (r_ei[w_po][v] == i_cmd.in_port);
                w_busy = (r_ei[w_po][v] != i_cmd.in_port);
            end
        for (int v = NUM_VCS - 1; v >= 0; v--)
            if (CW'(v) < r_cnt[w_po] && r_ei[w_po][v] == i_cmd.in_port &&
                r_ev[w_po][v] == i_cmd.in_vc) begin
                w_hit = 1'b1; w_hidx = VW'(v);
            end
        priority if (!(i_cmd.po_ok && i_cmd.pair_ok)) w_chk = ST_MISS;
        else if (|w_other) w_chk = ST_OTHER;
        else if (w_same)   w_chk = ST_SAME;
        else if (w_busy)   w_chk = ST_BUSY;
        else               w_chk = ST_OK;
    end

    // query match for the output being scanned
    logic w_qm;
    always_comb begin
        w_qm = (r_cnt[r_o] != '0) && (r_ei[r_o][r_rr[r_o]] == r_cmd.in_port);
    end

    logic w_lastq;
    always_comb begin
        w_lastq = 1'b1;
        for (int o = 0; o < NUM_OUTPUTS; o++)
            if (OW'(o) > r_o && r_cnt[o] != '0 && r_ei[o][r_rr[o]] == r_cmd.in_port)
                w_lastq = 1'b0;
    end

    // query beat: a hit on the scanned output, else the lone no-match beat
    t_res w_qres;
    always_comb begin
        w_qres = '0;
        w_qres.last = 1'b1;
        if (w_qm) begin
            w_qres.found       = 1'b1;
            w_qres.granted_out = 3'(r_o);
            w_qres.granted_vc  = r_ev[r_o][r_rr[r_o]];
            w_qres.last        = w_lastq;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res = r_res;

    t_res w_one;
    always_comb begin
        w_one = '0;
        w_one.last = 1'b1;
        w_one.status = w_chk;
        if (i_cmd.op == OP_RELEASE) w_one.status = (i_cmd.po_ok && w_hit) ? ST_OK : ST_MISS;
        if (i_cmd.op == OP_FREE) begin
            w_one.status = i_cmd.po_ok ? ST_OK : ST_MISS;
            w_one.out_free = i_cmd.po_ok && (r_cnt[w_po] == '0);
        end
        if (i_cmd.op == OP_RESERVE && w_chk == ST_OK && r_cnt[w_po] == CW'(NUM_VCS))
            w_one.status = ST_MISS;
    end

    // sequencer and table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int o = 0; o < NUM_OUTPUTS; o++) begin
                r_cnt[o] <= '0;
                r_rr[o]  <= '0;
            end
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_cmd_valid && !r_ov) begin
                    r_cmd <= i_cmd;
                    unique case (i_cmd.op)
                        OP_QUERY: begin
                            r_o <= '0; r_any <= 1'b0; r_state <= S_QUERY;
                        end
                        OP_TICK: begin
                            for (int o = 0; o < NUM_OUTPUTS; o++)
                                if (r_cnt[o] != '0)
                                    r_rr[o] <= (CW'(r_rr[o]) + 1'b1 == r_cnt[o]) ? '0
                                               : r_rr[o] + 1'b1;
                        end
                        default: begin
                            r_res <= w_one; r_ov <= 1'b1;
                            if (i_cmd.op == OP_RESERVE && w_one.status == ST_OK) begin
                                r_ei[w_po][r_cnt[w_po][VW-1:0]] <= i_cmd.in_port;
                                r_ev[w_po][r_cnt[w_po][VW-1:0]] <= i_cmd.in_vc;
                                r_cnt[w_po] <= r_cnt[w_po] + 1'b1;
                            end
                            if (i_cmd.op == OP_RELEASE && i_cmd.po_ok && w_hit) begin
                                for (int v = 0; v < NUM_VCS - 1; v++)
                                    if (VW'(v) >= w_hidx) begin
                                        r_ei[w_po][v] <= r_ei[w_po][v + 1];
                                        r_ev[w_po][v] <= r_ev[w_po][v + 1];
                                    end
                                r_cnt[w_po] <= r_cnt[w_po] - 1'b1;
                                if (w_hidx < r_rr[w_po])
                                    r_rr[w_po] <= r_rr[w_po] - 1'b1;
                                else if (CW'(r_rr[w_po]) >= r_cnt[w_po] - 1'b1)
                                    r_rr[w_po] <= '0;
                            end
                        end
                    endcase
                end
                S_QUERY: begin
                    if (w_qm) begin
                        r_res <= w_qres;
                        r_ov <= 1'b1; r_any <= 1'b1;
                        r_state <= S_OUT;
                    end else if (32'(r_o) == NUM_OUTPUTS - 1) begin
                        if (!r_any) begin
                            r_res <= w_qres; r_ov <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else r_o <= r_o + 1'b1;
                end
                S_OUT: if (r_ov && i_ready) begin
                    if (r_res.last || 32'(r_o) == NUM_OUTPUTS - 1) r_state <= S_IDLE;
                    else begin r_o <= r_o + 1'b1; r_state <= S_QUERY; end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/switch_reservation_table_rr.sv =====
`default_nettype none
// channel | dir | tdata (low bit up)                        | tuser | tlast
// s_axis  | in  | op[2:0] in_port[5:3] in_vc[7:6] out_port[10:8] | -   | -
// m_axis  | out | status[2:0] found[3] granted_out[6:4]
//         |     | granted_vc[8:7] out_free[9]                 | -     | last
// check, reserve, release and free test: each gives one result beat, registered
// in the back end after the command leaves the queue; tick gives no beat.
// a query goes to the scan sequencer, which scans one output per cycle but
// holds on each hit until its result beat is taken; with no hit it gives the
// lone no-match beat.
// reset is synchronous, active low; it clears counts, indexes, pointers and control state only.
// a two-deep command queue lets input beats be taken while a result stalls.
module switch_reservation_table_rr #(
    parameter int NUM_OUTPUTS = 5,
    parameter int NUM_INPUTS  = 5,
    parameter int NUM_VCS     = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // op, in_port, in_vc, out_port
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // status, found, granted_out, granted_vc, out_free
    output logic             m_axis_tlast
);
    import srt_pkg::*;

    t_cmd w_cmd;
    logic w_cv, w_cr;
    t_res w_res;

    // front: accept and queue
    srt_front #(.NUM_OUTPUTS(NUM_OUTPUTS), .NUM_INPUTS(NUM_INPUTS), .NUM_VCS(NUM_VCS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[10:0]), .o_cmd(w_cmd), .o_cmd_valid(w_cv), .i_cmd_ready(w_cr)
    );

    // back: table and results
    srt_back #(.NUM_OUTPUTS(NUM_OUTPUTS), .NUM_VCS(NUM_VCS)) u_back (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cmd_valid(w_cv), .o_cmd_ready(w_cr),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.out_free, w_res.granted_vc, w_res.granted_out,
                           w_res.found, w_res.status};
    assign m_axis_tlast = w_res.last;
endmodule
`default_nettype wire
